/* design/lmcs_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmcs_pkg
// Shared types, sizes and the row-select sequence for the LED column scanner.
// ---------------------------------------------------------------------------
package lmcs_pkg;

  localparam int NUM_COLUMNS     = 16;
  localparam int BITS_PER_COLUMN = 48;
  localparam int COL_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int POS_W   = (BITS_PER_COLUMN > 1) ? $clog2(BITS_PER_COLUMN) : 1;
  localparam int SEQ_LEN = 16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [3:0] pixel_column;
    logic [5:0] pixel_position;
    logic       pixel_value;
  } cmd_t;

  typedef struct packed {
    logic       serial_bit;
    logic       end_of_column;
    logic       select_pos_a;
    logic       select_pos_b;
    logic       select_neg_a;
    logic       select_neg_b;
    logic [3:0] column_shown;
  } result_t;

  typedef struct packed {
    logic nb;
    logic na;
    logic pb;
    logic pa;
  } sel_t;

  // one queued scan beat: column snapshot plus its select lines
  typedef struct packed {
    logic [BITS_PER_COLUMN-1:0] word;
    logic [3:0]                 shown;
    sel_t                       sel;
  } scan_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic sel_t sel_update(sel_t s, logic [COL_W-1:0] col);
    sel_t r;
    logic [COL_W+3:0] ext;
    r   = s;
    ext = {4'b0000, col};
    if (int'(col) < SEQ_LEN) begin
      unique case (ext[1:0])
        2'd0: begin
          r.nb = 1'b0;
          unique case (ext[3:2])
            2'd0: r.pb = 1'b0;
            2'd1: r.pa = 1'b1;
            2'd2: r.pb = 1'b1;
            default: r.pa = 1'b0;
          endcase
        end
        2'd1: r.na = 1'b1;
        2'd2: r.nb = 1'b1;
        default: r.na = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

/* design/lmcs_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmcs_front
// Takes commands, holds the frame store, column counter and select lines,
// and queues a column snapshot for each scan tick.
// ---------------------------------------------------------------------------
module lmcs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  lmcs_pkg::cmd_t cmd,
  output logic           push,
  output lmcs_pkg::scan_t entry
);
  import lmcs_pkg::*;

  logic [BITS_PER_COLUMN-1:0] frame_store [NUM_COLUMNS];
  logic [COL_W-1:0]           col;
  logic [COL_W-1:0]           col_next;
  sel_t                       sel;
  sel_t                       sel_next;
  logic [COL_W+3:0]           wcol_ext;
  logic [POS_W+5:0]           wpos_ext;
  logic [COL_W+3:0]           col_ext;
  logic                       wr_en;

  assign wcol_ext = {{COL_W{1'b0}}, cmd.pixel_column};
  assign wpos_ext = {{POS_W{1'b0}}, cmd.pixel_position};
  assign col_ext  = {4'b0000, col};
  assign wr_en    = accept && (cmd.mode == MODE_WRITE)
                    && (int'(cmd.pixel_column) < NUM_COLUMNS)
                    && (int'(cmd.pixel_position) < BITS_PER_COLUMN);

  assign push     = accept && (cmd.mode == MODE_SCAN);
  assign sel_next = sel_update(sel, col);
  assign col_next = (col == COL_W'(NUM_COLUMNS - 1)) ? '0 : col + 1'b1;

  assign entry.word  = frame_store[col];
  assign entry.shown = col_ext[3:0];
  assign entry.sel   = sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        frame_store[i] <= '0;
      end
      col <= '0;
      sel <= '0;
    end else begin
      if (wr_en) begin
        frame_store[wcol_ext[COL_W-1:0]][wpos_ext[POS_W-1:0]] <= cmd.pixel_value;
      end
      if (push) begin
        col <= col_next;
        sel <= sel_next;
      end
    end
  end

endmodule

/* design/lmcs_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmcs_queue
// Two-entry queue of scan beats between front and shifter.
// ---------------------------------------------------------------------------
module lmcs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lmcs_pkg::scan_t  wr_data,
  input  logic             pop,
  output lmcs_pkg::scan_t  rd_data,
  output lmcs_pkg::q_stat_t stat
);
  import lmcs_pkg::*;

  scan_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rd_data    = slots[rd_ptr];
  assign stat.valid = (count != 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/lmcs_shifter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmcs_shifter
// Shifts each queued column out one bit per clock, highest index first.
// ---------------------------------------------------------------------------
module lmcs_shifter (
  input  logic              clk,
  input  logic              rst,
  input  lmcs_pkg::q_stat_t stat,
  input  lmcs_pkg::scan_t   rd_data,
  output logic              pop,
  output logic              strobe,
  output lmcs_pkg::result_t result
);
  import lmcs_pkg::*;

  logic                       active;
  logic [BITS_PER_COLUMN-1:0] word;
  logic [POS_W-1:0]           cnt;
  sel_t                       sel;
  logic [3:0]                 shown;
  logic                       last;

  assign last   = (cnt == '0);
  assign pop    = stat.valid && (!active || last);
  assign strobe = active;

  assign result.serial_bit    = word[BITS_PER_COLUMN-1];
  assign result.end_of_column = active && last;
  assign result.select_pos_a  = sel.pa;
  assign result.select_pos_b  = sel.pb;
  assign result.select_neg_a  = sel.na;
  assign result.select_neg_b  = sel.nb;
  assign result.column_shown  = shown;

  always_ff @(posedge clk) begin
    if (pop) begin
      word  <= rd_data.word;
      sel   <= rd_data.sel;
      shown <= rd_data.shown;
      cnt   <= POS_W'(BITS_PER_COLUMN - 1);
    end else if (active) begin
      word <= word << 1;
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (active && last) begin
      active <= 1'b0;
    end
  end

endmodule

/* design/led_matrix_column_scanner_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_matrix_column_scanner_core
// Scan driver for a multiplexed LED matrix with a 16 x 48 bit frame store.
//
// A command beat is taken when start is high and busy is low. A pixel write
// (mode 0) updates the frame store and gives no result. A scan tick (mode 1)
// snapshots the current column with its updated row-select lines into a
// two-deep queue; the shifter then emits 48 result beats, one per clock,
// highest bit first, end_of_column set on the last. The tick is registered
// in the queue and then loaded into the shifter before its first beat is on
// the ports. Successive ticks stream without gaps. busy is high while the
// queue holds two ticks; writes are still taken while a column shifts out,
// as long as busy is low. Each result stands on the ports for one cycle
// under strobe and cannot be held off by the receiver. Synchronous reset
// clears the frame store, column counter, select lines and the queue.
// ---------------------------------------------------------------------------
module led_matrix_column_scanner_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lmcs_pkg::cmd_t    cmd,
  output logic              strobe,
  output lmcs_pkg::result_t result
);
  import lmcs_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  scan_t   wr_data;
  scan_t   rd_data;
  q_stat_t stat;

  assign busy   = stat.full;
  assign accept = start && !busy;

  lmcs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .push   (push),
    .entry  (wr_data)
  );

  lmcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .stat    (stat)
  );

  lmcs_shifter u_shifter (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .rd_data (rd_data),
    .pop     (pop),
    .strobe  (strobe),
    .result  (result)
  );

  a_eoc_strobed: assert property (@(posedge clk) disable iff (rst)
    result.end_of_column |-> strobe)
    else $error("end_of_column without strobe");

  a_column_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.end_of_column |=> strobe
      && result.column_shown == $past(result.column_shown)
      && result.select_neg_a == $past(result.select_neg_a)
      && result.select_pos_a == $past(result.select_pos_a))
    else $error("column beats broken up");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("activity straight after reset");

endmodule
